// ===== rtl/png_row_unfilter_top_assert.svh =====
// Assertion macros shared by the scanline reconstruction RTL
`ifndef PNG_ROW_UNFILTER_TOP_ASSERT_SVH
`define PNG_ROW_UNFILTER_TOP_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define PRU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent
`define PRU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pru_pkg.sv =====
// Package: shared types, constants and predictor functions for the unfilter
`default_nettype none

package pru_pkg;

   localparam int unsigned PIX_W          = 8;
   localparam int unsigned ROW_WIDTH_W    = 13;
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd320;

   typedef enum logic [2:0] {
      FLT_NONE  = 3'd0,
      FLT_SUB   = 3'd1,
      FLT_UP    = 3'd2,
      FLT_AVG   = 3'd3,
      FLT_PAETH = 3'd4
   } filter_kind_type;

   // Per-pixel command from the sequencer to the reconstruction stage
   typedef struct packed {
      logic [PIX_W-1:0] data;
      filter_kind_type  filter;
      logic             first_row;
      logic             col_zero;
      logic             row_end;
   } pix_cmd_type;

   // Unknown filter codes fall back to None
   function automatic filter_kind_type decode_filter(input logic [PIX_W-1:0] code);
      filter_kind_type kind;
      kind = FLT_NONE;
      if (code[PIX_W-1:3] == '0 && code[2:0] <= FLT_PAETH) begin
         kind = filter_kind_type'(code[2:0]);
      end
      return kind;
   endfunction

   // Paeth predictor, tie order left, up, upper-left
   function automatic logic [PIX_W-1:0] paeth_pred(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b,
                                                   input logic [PIX_W-1:0] c);
      logic signed [PIX_W+1:0] da;
      logic signed [PIX_W+1:0] db;
      logic signed [PIX_W+1:0] dc;
      logic        [PIX_W+1:0] pa;
      logic        [PIX_W+1:0] pb;
      logic        [PIX_W+1:0] pc;
      logic        [PIX_W-1:0] pick;
      da = $signed({2'b00, b}) - $signed({2'b00, c});
      db = $signed({2'b00, a}) - $signed({2'b00, c});
      dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
      pa = (da < 0) ? (PIX_W+2)'(-da) : (PIX_W+2)'(da);
      pb = (db < 0) ? (PIX_W+2)'(-db) : (PIX_W+2)'(db);
      pc = (dc < 0) ? (PIX_W+2)'(-dc) : (PIX_W+2)'(dc);
      if (pa <= pb && pa <= pc) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/png_row_unfilter_top.sv =====
// Top level: PNG scanline unfilter, one byte per pixel, line store in RAM
// Throughput: one byte per cycle sustained while results are taken, filter bytes included.
// Path: a pixel byte goes through the command register and line store read, then the
// result register that drives rsp; filter bytes give none.
// Reset: synchronous; row_width returns to 320; next byte is a first-row filter byte;
// the line store is not cleared; reading it only after being written is up to the user.
`default_nettype none
`include "png_row_unfilter_top_assert.svh"

module png_row_unfilter_top #(
   parameter int unsigned MAX_WIDTH = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [pru_pkg::PIX_W-1:0]         req_data_byte,
   input  wire logic                              req_start_image,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [pru_pkg::PIX_W-1:0]              rsp_pixel,
   output logic                                   rsp_row_end,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [pru_pkg::ROW_WIDTH_W-1:0]   csr_row_width
);

   import pru_pkg::*;

   localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic              s1_free;
   logic              cmd_valid;
   pix_cmd_type       cmd;
   logic [AW-1:0]     cmd_addr;
   logic              rd_en;
   logic [PIX_W-1:0]  rd_data;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [PIX_W-1:0]  wr_data;

   // Front stage: take each transfer, decode the filter byte, track the
   // column and issue the read of the pixel above for each pixel byte not in a first row.
   pru_seq #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_start_image (req_start_image),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_row_width   (csr_row_width),
      .s1_free         (s1_free),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_addr        (cmd_addr),
      .rd_en           (rd_en)
   );

   // Line store: one row of reconstructed pixels. A column is read one
   // byte after its write in the row before at the earliest (the filter
   // byte sits between), so no forwarding path is needed.
   pru_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cmd_addr),
      .rd_data (rd_data)
   );

   // Back stage: predict from left, up and upper-left, write the pixel
   // back to the line store and hold it in the result register.
   pru_recon #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_recon (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_addr    (cmd_addr),
      .rd_data     (rd_data),
      .s1_free     (s1_free),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_pixel   (rsp_pixel),
      .rsp_row_end (rsp_row_end)
   );

   function automatic logic rd_addr_differs();
      return cmd_addr != wr_addr;
   endfunction

   // Read and write never meet on one entry in the same cycle
   `PRU_ASSERT_SAME(a_no_rw_clash, clock, reset, rd_en && wr_en, rd_addr_differs(),
                    "line store read and write hit the same entry")
   // Hold a result that is not taken, payload unchanged
   `PRU_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_pixel) && $stable(rsp_row_end),
                    "result dropped or changed while waiting")
   // Input stalls only behind a result that is not taken
   `PRU_ASSERT_SAME(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready,
                    "input stalled without a waiting result")

endmodule

`default_nettype wire

// ===== rtl/pru_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data
`default_nettype none

module pru_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pru_seq.sv =====
// Row sequencer: filter byte decode, column tracking, line store read issue
`default_nettype none

module pru_seq #(
   parameter int unsigned MAX_WIDTH = 4096,
   localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [pru_pkg::PIX_W-1:0]         req_data_byte,
   input  wire logic                              req_start_image,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [pru_pkg::ROW_WIDTH_W-1:0]   csr_row_width,
   input  wire logic                              s1_free,
   output logic                                   cmd_valid,
   output pru_pkg::pix_cmd_type                   cmd,
   output logic [AW-1:0]                          cmd_addr,
   output logic                                   rd_en
);

   import pru_pkg::*;

   localparam int unsigned CMPW = ((AW + 1 > ROW_WIDTH_W) ? AW + 1 : ROW_WIDTH_W) + 1;

   logic [ROW_WIDTH_W-1:0] row_width_ff, row_width_in;
   logic [AW-1:0]          column_ff, column_in;
   logic                   awaiting_ff, awaiting_in;
   logic                   first_row_ff, first_row_in;
   filter_kind_type        filter_ff, filter_in;

   logic            accept;
   logic            first_eff;
   logic            await_eff;
   logic [CMPW-1:0] width_sat;
   logic [CMPW-1:0] col_next;
   logic            last;

   assign req_ready = s1_free;
   assign csr_ready = 1'b1;
   assign accept    = req_valid & s1_free;
   assign first_eff = req_start_image | first_row_ff;
   assign await_eff = req_start_image | awaiting_ff;

   // saturate width to 1..MAX_WIDTH
   always_comb begin
      if (row_width_ff == '0) begin
         width_sat = CMPW'(1);
      end else if (CMPW'(row_width_ff) > CMPW'(MAX_WIDTH)) begin
         width_sat = CMPW'(MAX_WIDTH);
      end else begin
         width_sat = CMPW'(row_width_ff);
      end
   end

   assign col_next = CMPW'(column_ff) + CMPW'(1);
   assign last     = (col_next >= width_sat);

   always_comb begin
      row_width_in = row_width_ff;
      column_in    = column_ff;
      awaiting_in  = awaiting_ff;
      first_row_in = first_row_ff;
      filter_in    = filter_ff;
      if (csr_valid) begin
         row_width_in = csr_row_width;
      end
      if (accept) begin
         if (await_eff) begin
            filter_in    = decode_filter(req_data_byte);
            column_in    = '0;
            awaiting_in  = 1'b0;
            first_row_in = first_eff;
         end else if (last) begin
            column_in    = '0;
            awaiting_in  = 1'b1;
            first_row_in = 1'b0;
         end else begin
            column_in    = AW'(col_next);
            first_row_in = first_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         column_ff    <= '0;
         awaiting_ff  <= 1'b1;
         first_row_ff <= 1'b1;
         filter_ff    <= FLT_NONE;
      end else begin
         row_width_ff <= row_width_in;
         column_ff    <= column_in;
         awaiting_ff  <= awaiting_in;
         first_row_ff <= first_row_in;
         filter_ff    <= filter_in;
      end
   end

   assign cmd_valid = accept & ~await_eff;
   assign rd_en     = cmd_valid & ~first_eff;
   assign cmd_addr  = column_ff;
   assign cmd       = '{data:      req_data_byte,
                        filter:    filter_ff,
                        first_row: first_eff,
                        col_zero:  (column_ff == '0),
                        row_end:   last};

endmodule

`default_nettype wire

// ===== rtl/pru_recon.sv =====
// Reconstruction stage: predictor, line store write-back and result register
`default_nettype none
`include "png_row_unfilter_top_assert.svh"

module pru_recon #(
   parameter int unsigned MAX_WIDTH = 4096,
   localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        cmd_valid,
   input  wire pru_pkg::pix_cmd_type        cmd,
   input  wire logic [AW-1:0]               cmd_addr,
   input  wire logic [pru_pkg::PIX_W-1:0]   rd_data,
   output logic                             s1_free,
   output logic                             wr_en,
   output logic [AW-1:0]                    wr_addr,
   output logic [pru_pkg::PIX_W-1:0]        wr_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [pru_pkg::PIX_W-1:0]        rsp_pixel,
   output logic                             rsp_row_end
);

   import pru_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   pix_cmd_type       s1_cmd_ff, s1_cmd_in;
   logic [AW-1:0]     s1_addr_ff, s1_addr_in;
   logic [PIX_W-1:0]  left_ff, left_in;
   logic [PIX_W-1:0]  ul_ff, ul_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pixel_ff, rsp_pixel_in;
   logic              rsp_row_end_ff, rsp_row_end_in;

   logic              s1_adv;
   logic [PIX_W-1:0]  a, b, c;
   logic [PIX_W-1:0]  pred;
   logic [PIX_W:0]    ab_sum;
   logic [PIX_W-1:0]  result;

   assign s1_adv  = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign s1_free = ~s1_valid_ff | s1_adv;

   // neighbours: zero at column 0, zero row above in the first row
   assign a      = s1_cmd_ff.col_zero ? '0 : left_ff;
   assign c      = s1_cmd_ff.col_zero ? '0 : ul_ff;
   assign b      = s1_cmd_ff.first_row ? '0 : rd_data;
   assign ab_sum = {1'b0, a} + {1'b0, b};

   always_comb begin
      case (s1_cmd_ff.filter)
         FLT_SUB:   pred = a;
         FLT_UP:    pred = b;
         FLT_AVG:   pred = ab_sum[PIX_W:1];
         FLT_PAETH: pred = paeth_pred(a, b, c);
         default:   pred = '0;
      endcase
   end

   assign result  = s1_cmd_ff.data + pred;
   assign wr_en   = s1_adv;
   assign wr_addr = s1_addr_ff;
   assign wr_data = result;

   always_comb begin
      s1_valid_in    = cmd_valid | (s1_valid_ff & ~s1_adv);
      s1_cmd_in      = cmd_valid ? cmd : s1_cmd_ff;
      s1_addr_in     = cmd_valid ? cmd_addr : s1_addr_ff;
      left_in        = s1_adv ? result : left_ff;
      ul_in          = s1_adv ? b : ul_ff;
      rsp_valid_in   = s1_adv | (rsp_valid_ff & ~rsp_ready);
      rsp_pixel_in   = s1_adv ? result : rsp_pixel_ff;
      rsp_row_end_in = s1_adv ? s1_cmd_ff.row_end : rsp_row_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff      <= s1_cmd_in;
      s1_addr_ff     <= s1_addr_in;
      left_ff        <= left_in;
      ul_ff          <= ul_in;
      rsp_pixel_ff   <= rsp_pixel_in;
      rsp_row_end_ff <= rsp_row_end_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pixel   = rsp_pixel_ff;
   assign rsp_row_end = rsp_row_end_ff;

   `PRU_ASSERT_NEXT(a_cmd_lands, clock, reset, cmd_valid, s1_valid_ff,
                    "pixel command lost on entry to reconstruction stage")
   `PRU_ASSERT_NEXT(a_stall_holds_rd, clock, reset, s1_valid_ff && !s1_adv,
                    $stable(rd_data), "line store data changed under a stalled pixel")
   `PRU_ASSERT_NEXT(a_adv_gives_rsp, clock, reset, s1_adv, rsp_valid_ff,
                    "advanced pixel did not reach the result register")

endmodule

`default_nettype wire

// ===== tb/png_row_unfilter_top_test.sv =====
// Self-checking testbench for the PNG scanline unfilter: directed table, then random images
`timescale 1ns / 100ps

module png_row_unfilter_top_test;
   import pru_pkg::*;

   localparam int unsigned ROW_MAX       = 4096;
   localparam int unsigned RANDOM_BYTES  = 500;
   // Filter bytes give nothing, so allow a margin
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned DRAIN_LIMIT   = 5000;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             row_end;
   } pixel_result_type;

   typedef enum logic {STEP_BYTE, STEP_CSR} step_kind_type;

   typedef struct {
      step_kind_type          kind;
      logic [ROW_WIDTH_W-1:0] value;    // byte, or new row width
      bit                     start;
      bit                     fixed;    // expectation typed in below
      logic [PIX_W-1:0]       pix;
      bit                     last;
   } dir_step_type;

   // Directed table: rows of width 2 through every filter, wrap-around, an unknown filter
   // code, a new image in mid-row, a width cut in mid-row and the width extremes.
   localparam int unsigned N_DIRECTED = 28;
   dir_step_type directed_steps [N_DIRECTED] = '{
      '{STEP_CSR,  13'd2,              1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'(FLT_NONE),      1'b1, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'h00,             1'b0, 1'b1, 8'h00, 1'b0},
      '{STEP_BYTE, 13'hFF,             1'b0, 1'b1, 8'hFF, 1'b1},
      '{STEP_BYTE, 13'(FLT_SUB),       1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'h01,             1'b0, 1'b1, 8'h01, 1'b0},
      '{STEP_BYTE, 13'hFF,             1'b0, 1'b1, 8'h00, 1'b1},
      '{STEP_BYTE, 13'(FLT_UP),        1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'h7F,             1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'h80,             1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'(FLT_AVG),       1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'h40,             1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'hC3,             1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'(FLT_PAETH),     1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'h11,             1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'hEE,             1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'h05,             1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'h5A,             1'b0, 1'b1, 8'h5A, 1'b0},
      '{STEP_BYTE, 13'(FLT_UP),        1'b1, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'h33,             1'b0, 1'b1, 8'h33, 1'b0},
      '{STEP_BYTE, 13'h44,             1'b0, 1'b1, 8'h44, 1'b1},
      '{STEP_BYTE, 13'(FLT_PAETH),     1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'h20,             1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_CSR,  13'd0,              1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'h9C,             1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'(FLT_SUB),       1'b0, 1'b0, 8'h00, 1'b0},
      '{STEP_BYTE, 13'h7F,             1'b0, 1'b1, 8'h7F, 1'b1},
      '{STEP_CSR,  13'd8191,           1'b0, 1'b0, 8'h00, 1'b0}
   };

   // Three more directed bytes follow the table: an Average first row at saturated width
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid       = 1'b0;
   logic                   req_ready;
   logic [PIX_W-1:0]       req_data_byte   = '0;
   logic                   req_start_image = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready       = 1'b0;
   logic [PIX_W-1:0]       rsp_pixel;
   logic                   rsp_row_end;
   logic                   csr_valid       = 1'b0;
   logic                   csr_ready;
   logic [ROW_WIDTH_W-1:0] csr_row_width   = '0;

   // Shadow of the block: line store, neighbours, row position and the width register
   logic [PIX_W-1:0]       line_pix     [ROW_MAX];
   bit                     line_written [ROW_MAX];
   logic [PIX_W-1:0]       left_pix;
   logic [PIX_W-1:0]       upleft_pix;
   filter_kind_type        cur_filter;
   int unsigned            col_pos;
   bit                     want_filter;
   bit                     top_row;
   logic [ROW_WIDTH_W-1:0] row_width_shadow;

   pixel_result_type pending_pixels [$];
   int               mismatch_count = 0;
   int               tx_quiet = 0;
   int               rx_quiet = 0;

   png_row_unfilter_top #(
      .MAX_WIDTH (ROW_MAX)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_start_image (req_start_image),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel       (rsp_pixel),
      .rsp_row_end     (rsp_row_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_row_width   (csr_row_width)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatch_count++;
   endtask

   // Mostly a random idle gap before each transfer, with the odd stretch of back-to-back transfers
   function automatic int draw_gap(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         quiet = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   // Reconstruct one byte; returns 1 when the byte yields a pixel
   function automatic bit predict_byte(input logic [PIX_W-1:0] data, input bit start,
                                       output pixel_result_type res);
      int unsigned      eff_width;
      logic [PIX_W-1:0] a;
      logic [PIX_W-1:0] b;
      logic [PIX_W-1:0] c;
      logic [PIX_W-1:0] guess;
      int               pa;
      int               pb;
      int               pc;
      res = '0;
      eff_width = (row_width_shadow == 0) ? 1 :
                  ((row_width_shadow > ROW_MAX) ? ROW_MAX : row_width_shadow);
      if (start) begin
         top_row     = 1'b1;
         want_filter = 1'b1;
      end
      if (want_filter) begin
         cur_filter  = (data <= FLT_PAETH) ? filter_kind_type'(data[2:0]) : FLT_NONE;
         col_pos     = 0;
         left_pix    = '0;
         upleft_pix  = '0;
         want_filter = 1'b0;
         return 1'b0;
      end
      a = left_pix;
      b = top_row ? '0 : line_pix[col_pos];
      c = upleft_pix;
      case (cur_filter)
         FLT_SUB: guess = a;
         FLT_UP:  guess = b;
         FLT_AVG: guess = PIX_W'((int'(a) + int'(b)) >> 1);
         FLT_PAETH: begin
            pa = int'(b) - int'(c);
            pb = int'(a) - int'(c);
            pc = int'(a) + int'(b) - 2 * int'(c);
            if (pa < 0) pa = -pa;
            if (pb < 0) pb = -pb;
            if (pc < 0) pc = -pc;
            guess = (pa <= pb && pa <= pc) ? a : ((pb <= pc) ? b : c);
         end
         default: guess = '0;
      endcase
      res.pixel             = data + guess;
      line_pix[col_pos]     = res.pixel;
      line_written[col_pos] = 1'b1;
      left_pix              = res.pixel;
      upleft_pix            = b;
      res.row_end           = (col_pos + 1 >= eff_width);
      if (res.row_end) begin
         want_filter = 1'b1;
         top_row     = 1'b0;
         col_pos     = 0;
      end else begin
         col_pos++;
      end
      return 1'b1;
   endfunction

   // Offer one byte, hold it until the transfer, then log the pixel it should give.
   // Valid stays high across back-to-back transfers; this task lowers it only for a gap.
   task automatic send_byte(input logic [PIX_W-1:0] data, input bit start, input bit fixed,
                            input pixel_result_type fixed_res, output bit produced);
      int               gap;
      pixel_result_type res;
      gap = draw_gap(tx_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= data;
      req_start_image <= start;
      do @(posedge clock); while (!req_ready);
      produced = predict_byte(data, start, res);
      if (produced) begin
         pending_pixels.push_back(fixed ? fixed_res : res);
      end
   endtask

   // Write the width only once the block has drained: drop valid, wait for every pending
   // pixel, then give a trailing filter byte time to settle before the transfer.
   task automatic set_row_width(input logic [ROW_WIDTH_W-1:0] width);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid     <= 1'b1;
      csr_row_width <= width;
      do @(posedge clock); while (!csr_ready);
      csr_valid        <= 1'b0;
      row_width_shadow  = width;
   endtask

   // Stimulus: directed table first, then random images
   initial begin
      bit                     produced;
      bit                     start;
      bit                     wide_phase;
      bit                     wide_done;
      bit                     first;
      logic [PIX_W-1:0]       data;
      logic [ROW_WIDTH_W-1:0] width;
      pixel_result_type       fixed_res;
      int                     normal_bytes;
      int                     target;
      int                     got;
      int                     waited;

      // Mirror the reset state of the block
      left_pix         = '0;
      upleft_pix       = '0;
      cur_filter       = FLT_NONE;
      col_pos          = 0;
      want_filter      = 1'b1;
      top_row          = 1'b1;
      row_width_shadow = ROW_WIDTH_RESET;
      foreach (line_written[i]) line_written[i] = 1'b0;
      foreach (line_pix[i]) line_pix[i] = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR) begin
            set_row_width(directed_steps[i].value);
         end else begin
            fixed_res.pixel   = directed_steps[i].pix;
            fixed_res.row_end = directed_steps[i].last;
            send_byte(directed_steps[i].value[PIX_W-1:0], directed_steps[i].start,
                      directed_steps[i].fixed, fixed_res, produced);
         end
      end
      // Saturated width: first row under Average, left and up both zero on column 0
      fixed_res = '{pixel: 8'hAB, row_end: 1'b0};
      send_byte(PIX_W'(FLT_AVG), 1'b1, 1'b0, fixed_res, produced);
      send_byte(8'hAB, 1'b0, 1'b1, fixed_res, produced);
      send_byte(8'h02, 1'b0, 1'b0, fixed_res, produced);

      // Random phases: each sets a width, then streams well-formed rows with random
      // filters and pixels, spiced with new images mid-row. One phase runs at a width
      // at or above the largest row, so the saturation is exercised.
      normal_bytes = 0;
      wide_done    = 1'b0;
      while (normal_bytes < RANDOM_BYTES) begin
         wide_phase = !wide_done && normal_bytes >= RANDOM_BYTES / 2;
         if (wide_phase) begin
            wide_done = 1'b1;
            width     = $urandom_range(0, 1) ? 13'd4096 : 13'd8191;
            target    = $urandom_range(5, 30);
         end else begin
            case ($urandom_range(0, 9))
               0:       width = 13'd0;
               1:       width = 13'd1;
               2:       width = ROW_WIDTH_W'($urandom_range(9, 40));
               default: width = ROW_WIDTH_W'($urandom_range(2, 8));
            endcase
            target = $urandom_range(10, 60);
         end
         set_row_width(width);
         got   = 0;
         first = 1'b1;
         while (got < target) begin
            if (first) begin
               start = wide_phase || $urandom_range(0, 9) < 7;
            end else begin
               start = !wide_phase && $urandom_range(0, 33) == 0;
            end
            first = 1'b0;
            // Never read a line store entry that has not been written: open a new image
            if (!start && !want_filter && !top_row && !line_written[col_pos]) begin
               start = 1'b1;
            end
            if (start || want_filter) begin
               data = ($urandom_range(0, 9) < 8) ?
                      PIX_W'($urandom_range(FLT_NONE, FLT_PAETH)) :
                      PIX_W'($urandom_range(0, 255));
            end else begin
               case ($urandom_range(0, 9))
                  0:       data = 8'h00;
                  1:       data = 8'hFF;
                  default: data = PIX_W'($urandom_range(0, 255));
               endcase
            end
            send_byte(data, start, 1'b0, '0, produced);
            got += produced;
            if (!wide_phase) normal_bytes++;
         end
      end

      // Drain: wait for every pending pixel, then let any stray result show up
      req_valid <= 1'b0;
      waited = 0;
      while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_pixels.size() != 0) begin
         report_mismatch($sformatf("%0d pixels never arrived", pending_pixels.size()));
      end
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Receiver: random back-pressure, one long hold-off so the block fills and stalls its
   // input, and a field-by-field check of every transfer against the oldest pending pixel
   initial begin
      int               gap;
      int               rx_count;
      bit               held;
      pixel_result_type want;
      rx_count = 0;
      held     = 1'b0;
      wait (!reset);
      forever begin
         gap = draw_gap(rx_quiet);
         if (!held && rx_count >= 120) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         rx_count++;
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel %02h row_end %0b with nothing pending",
                                      rsp_pixel, rsp_row_end));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel !== want.pixel) begin
               report_mismatch($sformatf("pixel %02h, expected %02h", rsp_pixel, want.pixel));
            end
            if (rsp_row_end !== want.row_end) begin
               report_mismatch($sformatf("row_end %0b, expected %0b (pixel %02h)",
                                         rsp_row_end, want.row_end, want.pixel));
            end
         end
      end
   end

   // Watchdog: generous bound on the whole run
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
